### sv/mcdt_pkg.sv
// Package with the types, constants and arithmetic helpers of the deadline timer.
package mcdt_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned PERIOD_W = 24;
  localparam int unsigned EN_W = 4;
  localparam int unsigned SEL_W = 4;
  localparam int unsigned INDEX_W = 3;
  localparam int unsigned NUM_CH = 5;

  localparam int unsigned CH_CHECK = 0;
  localparam int unsigned CH_DUMP = 1;
  localparam int unsigned CH_IDLE = 2;
  localparam int unsigned CH_STATS = 3;
  localparam int unsigned CH_WHO = 4;

  localparam logic [PERIOD_W-1:0] STATS_PERIOD = PERIOD_W'(15);
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  localparam logic [PERIOD_W-1:0] DUMP_PERIOD_RST = PERIOD_W'(3600);
  localparam logic [PERIOD_W-1:0] CHECK_PERIOD_RST = PERIOD_W'(600);
  localparam logic [PERIOD_W-1:0] IDLE_PERIOD_RST = PERIOD_W'(60);
  localparam logic [PERIOD_W-1:0] WHO_PERIOD_RST = PERIOD_W'(241);
  localparam logic [EN_W-1:0] ENABLES_RST = EN_W'(15);

  typedef enum logic [1:0] {
    CMD_INIT = 2'd0,
    CMD_TICK = 2'd1,
    CMD_WARP = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [INDEX_W-1:0] {
    REG_DUMP_PERIOD        = 3'd0,
    REG_DUMP_FIRST_OFFSET  = 3'd1,
    REG_CHECK_PERIOD       = 3'd2,
    REG_CHECK_FIRST_OFFSET = 3'd3,
    REG_IDLE_PERIOD        = 3'd4,
    REG_WHO_PERIOD         = 3'd5,
    REG_CHANNEL_ENABLES    = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] dump_period;
    logic [PERIOD_W-1:0] dump_first_offset;
    logic [PERIOD_W-1:0] check_period;
    logic [PERIOD_W-1:0] check_first_offset;
    logic [PERIOD_W-1:0] idle_period;
    logic [PERIOD_W-1:0] who_period;
    logic [EN_W-1:0]     channel_enables;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [TIME_W-1:0] time_now;
    logic [SEL_W-1:0]  warp_select;
    logic [TIME_W-1:0] warp_seconds;
  } item_t;

  typedef struct packed {
    logic              fire_check;
    logic              fire_dump;
    logic              fire_idle;
    logic              fire_stats;
    logic              fire_who;
    logic [TIME_W-1:0] next_delay;
  } result_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [PERIOD_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W+1-PERIOD_W){1'b0}}, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] warp_sub(input logic [TIME_W-1:0] d,
                                                 input logic [TIME_W-1:0] secs);
    logic [TIME_W+1:0] r;
    r = {2'b00, d} - {{2{secs[TIME_W-1]}}, secs};
    if (r[TIME_W+1]) begin
      return '0;
    end else if (r[TIME_W]) begin
      return TIME_MAX;
    end
    return r[TIME_W-1:0];
  endfunction

endpackage

### sv/mcdt_cfg.sv
// Configuration register file of the deadline timer.
module mcdt_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [mcdt_pkg::INDEX_W-1:0]  wr_index,
  input  logic [mcdt_pkg::PERIOD_W-1:0] wr_data,
  output mcdt_pkg::cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dump_period        <= mcdt_pkg::DUMP_PERIOD_RST;
      cfg.dump_first_offset  <= '0;
      cfg.check_period       <= mcdt_pkg::CHECK_PERIOD_RST;
      cfg.check_first_offset <= '0;
      cfg.idle_period        <= mcdt_pkg::IDLE_PERIOD_RST;
      cfg.who_period         <= mcdt_pkg::WHO_PERIOD_RST;
      cfg.channel_enables    <= mcdt_pkg::ENABLES_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        mcdt_pkg::REG_DUMP_PERIOD:        cfg.dump_period <= wr_data;
        mcdt_pkg::REG_DUMP_FIRST_OFFSET:  cfg.dump_first_offset <= wr_data;
        mcdt_pkg::REG_CHECK_PERIOD:       cfg.check_period <= wr_data;
        mcdt_pkg::REG_CHECK_FIRST_OFFSET: cfg.check_first_offset <= wr_data;
        mcdt_pkg::REG_IDLE_PERIOD:        cfg.idle_period <= wr_data;
        mcdt_pkg::REG_WHO_PERIOD:         cfg.who_period <= wr_data;
        mcdt_pkg::REG_CHANNEL_ENABLES: begin
          cfg.channel_enables <= wr_data[mcdt_pkg::EN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### sv/mcdt_core.sv
// Deadline table, last time register and the combinational step logic.
module mcdt_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  mcdt_pkg::item_t   item,
  input  mcdt_pkg::cfg_t    cfg,
  output mcdt_pkg::result_t result
);

  logic [mcdt_pkg::TIME_W-1:0] deadline [mcdt_pkg::NUM_CH];
  logic [mcdt_pkg::TIME_W-1:0] deadline_next [mcdt_pkg::NUM_CH];
  logic [mcdt_pkg::TIME_W-1:0] last_time;
  logic [mcdt_pkg::TIME_W-1:0] last_time_next;
  logic [mcdt_pkg::NUM_CH-1:0] fire;
  logic [mcdt_pkg::TIME_W-1:0] earliest;
  logic [mcdt_pkg::TIME_W-1:0] now;
  logic [mcdt_pkg::TIME_W-1:0] secs;
  logic [mcdt_pkg::SEL_W-1:0]  sel;
  logic [mcdt_pkg::EN_W-1:0]   en;

  assign now = item.time_now;
  assign secs = item.warp_seconds;
  assign sel = item.warp_select;
  assign en = cfg.channel_enables;

  always_comb begin
    for (int i = 0; i < mcdt_pkg::NUM_CH; i++) begin
      deadline_next[i] = deadline[i];
    end
    last_time_next = last_time;
    fire = '0;
    unique case (mcdt_pkg::cmd_t'(item.command))
      mcdt_pkg::CMD_INIT: begin
        last_time_next = now;
        deadline_next[mcdt_pkg::CH_CHECK] = mcdt_pkg::sat_add(now,
          (cfg.check_first_offset == '0) ? cfg.check_period : cfg.check_first_offset);
        deadline_next[mcdt_pkg::CH_DUMP] = mcdt_pkg::sat_add(now,
          (cfg.dump_first_offset == '0) ? cfg.dump_period : cfg.dump_first_offset);
        deadline_next[mcdt_pkg::CH_IDLE] = mcdt_pkg::sat_add(now, cfg.idle_period);
        deadline_next[mcdt_pkg::CH_STATS] = mcdt_pkg::sat_add(now, mcdt_pkg::STATS_PERIOD);
        deadline_next[mcdt_pkg::CH_WHO] = mcdt_pkg::sat_add(now, cfg.who_period);
      end
      mcdt_pkg::CMD_TICK: begin
        last_time_next = now;
        fire[mcdt_pkg::CH_CHECK] = en[0] && (deadline[mcdt_pkg::CH_CHECK] <= now);
        fire[mcdt_pkg::CH_DUMP]  = en[1] && (deadline[mcdt_pkg::CH_DUMP] <= now);
        fire[mcdt_pkg::CH_IDLE]  = en[2] && (deadline[mcdt_pkg::CH_IDLE] <= now);
        fire[mcdt_pkg::CH_STATS] = (deadline[mcdt_pkg::CH_STATS] <= now);
        fire[mcdt_pkg::CH_WHO]   = en[3] && (deadline[mcdt_pkg::CH_WHO] <= now);
        if (fire[mcdt_pkg::CH_CHECK]) begin
          deadline_next[mcdt_pkg::CH_CHECK] = mcdt_pkg::sat_add(now, cfg.check_period);
        end
        if (fire[mcdt_pkg::CH_DUMP]) begin
          deadline_next[mcdt_pkg::CH_DUMP] = mcdt_pkg::sat_add(now, cfg.dump_period);
        end
        if (fire[mcdt_pkg::CH_IDLE]) begin
          deadline_next[mcdt_pkg::CH_IDLE] = mcdt_pkg::sat_add(now, cfg.idle_period);
        end
        if (fire[mcdt_pkg::CH_STATS]) begin
          deadline_next[mcdt_pkg::CH_STATS] = mcdt_pkg::sat_add(now, mcdt_pkg::STATS_PERIOD);
        end
        if (fire[mcdt_pkg::CH_WHO]) begin
          deadline_next[mcdt_pkg::CH_WHO] = mcdt_pkg::sat_add(now, cfg.who_period);
        end
      end
      mcdt_pkg::CMD_WARP: begin
        if (sel[0]) begin
          deadline_next[mcdt_pkg::CH_DUMP] =
            mcdt_pkg::warp_sub(deadline[mcdt_pkg::CH_DUMP], secs);
        end
        if (sel[1]) begin
          deadline_next[mcdt_pkg::CH_CHECK] =
            mcdt_pkg::warp_sub(deadline[mcdt_pkg::CH_CHECK], secs);
        end
        if (sel[2]) begin
          deadline_next[mcdt_pkg::CH_IDLE] =
            mcdt_pkg::warp_sub(deadline[mcdt_pkg::CH_IDLE], secs);
        end
        if (sel[3]) begin
          deadline_next[mcdt_pkg::CH_WHO] =
            mcdt_pkg::warp_sub(deadline[mcdt_pkg::CH_WHO], secs);
        end
      end
      mcdt_pkg::CMD_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    earliest = deadline_next[0];
    for (int i = 1; i < mcdt_pkg::NUM_CH; i++) begin
      if (deadline_next[i] < earliest) begin
        earliest = deadline_next[i];
      end
    end
    result.fire_check = fire[mcdt_pkg::CH_CHECK];
    result.fire_dump  = fire[mcdt_pkg::CH_DUMP];
    result.fire_idle  = fire[mcdt_pkg::CH_IDLE];
    result.fire_stats = fire[mcdt_pkg::CH_STATS];
    result.fire_who   = fire[mcdt_pkg::CH_WHO];
    result.next_delay = (earliest <= last_time_next) ? mcdt_pkg::TIME_W'(1)
                                                     : earliest - last_time_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mcdt_pkg::NUM_CH; i++) begin
        deadline[i] <= '0;
      end
      last_time <= '0;
    end else if (step) begin
      for (int i = 0; i < mcdt_pkg::NUM_CH; i++) begin
        deadline[i] <= deadline_next[i];
      end
      last_time <= last_time_next;
    end
  end

endmodule

### sv/multi_channel_deadline_timer.sv
// Top level of the five-channel deadline timer with its input and result registers.
//
// Commands arrive on the s_ channel: s_tuser carries the command (init, tick,
// warp or no operation) and s_tdata the current time, warp select and warp
// seconds. Every command item yields exactly one result item on the m_ channel
// with the five fire flags and the delay to the earliest deadline.
// An accepted item is captured in the input register; the step logic then updates
// the deadline table and the result register together once the result register
// is free, and m_tvalid rises with the result. One item per cycle is sustained
// while m_tready is high. When m_tready is low the result register holds its
// item; the input register still accepts one more item, and s_tready drops only
// when both are full. Reset clears the pipeline valid flags, all deadlines and
// the last time, and returns the configuration registers to their defaults.
// The user must write the configuration port (wr_en, wr_index, wr_data) only
// while the block is idle; the block itself does not enforce it.
module multi_channel_deadline_timer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // Fields from bit 0: time_now[31:0], warp_select[35:32], warp_seconds[67:36].
  input  logic [71:0]                   s_tdata,
  // Fields from bit 0: command[1:0].
  input  logic [1:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // Fields from bit 0: fire_check, fire_dump, fire_idle, fire_stats, fire_who,
  // next_delay[36:5].
  output logic [39:0]                   m_tdata,
  input  logic                          wr_en,
  input  logic [mcdt_pkg::INDEX_W-1:0]  wr_index,
  input  logic [mcdt_pkg::PERIOD_W-1:0] wr_data
);

  mcdt_pkg::cfg_t    cfg;
  mcdt_pkg::item_t   item;
  mcdt_pkg::result_t step_result;
  mcdt_pkg::result_t result;
  logic              item_valid;
  logic              advance;

  assign advance = item_valid && (!m_tvalid || m_tready);
  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.command      <= s_tuser;
      item.time_now     <= s_tdata[31:0];
      item.warp_select  <= s_tdata[35:32];
      item.warp_seconds <= s_tdata[67:36];
    end
  end

  mcdt_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  mcdt_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item),
    .cfg    (cfg),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_result;
    end
  end

  assign m_tdata = {3'b000, result.next_delay, result.fire_who, result.fire_stats,
                    result.fire_idle, result.fire_dump, result.fire_check};

endmodule
